>>> rtl/dtf_pkg.sv
// Shared types, constants and codes for the degenerate triangle filter.
package dtf_pkg;

   localparam int VERTEX_DEPTH_DEFAULT = 4096;
   localparam int COORD_BITS_DEFAULT   = 24;
   localparam int INDEX_W              = 12;
   localparam int POS_W                = 24;
   localparam int THRESH_W             = 64;
   localparam int CODE_W               = 2;

   localparam logic CMD_VERTEX   = 1'b0;
   localparam logic CMD_TRIANGLE = 1'b1;

   localparam logic [CODE_W-1:0] CODE_KEEP       = 2'd0;
   localparam logic [CODE_W-1:0] CODE_REPEAT     = 2'd1;
   localparam logic [CODE_W-1:0] CODE_COINCIDENT = 2'd2;
   localparam logic [CODE_W-1:0] CODE_SMALL_AREA = 2'd3;

   localparam logic [1:0] RD_SEL_A = 2'd0;
   localparam logic [1:0] RD_SEL_B = 2'd1;
   localparam logic [1:0] RD_SEL_C = 2'd2;

   localparam logic [THRESH_W-1:0] MIN_NORMAL_SQ_RESET = 64'd1;

   typedef struct packed {
      logic                     cmd;
      logic [INDEX_W-1:0]       vertex_slot;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic [INDEX_W-1:0]       corner_a;
      logic [INDEX_W-1:0]       corner_b;
      logic [INDEX_W-1:0]       corner_c;
      logic                     last_in;
   } dtf_req_type;

   typedef struct packed {
      logic                keep;
      logic [CODE_W-1:0]   reject_code;
      logic [INDEX_W-1:0]  out_a;
      logic [INDEX_W-1:0]  out_b;
      logic [INDEX_W-1:0]  out_c;
      logic                last_out;
   } dtf_rsp_type;

   typedef struct packed {
      logic       vtx_write;
      logic       capture_req;
      logic [1:0] rd_sel;
      logic       load_p0;
      logic       load_p1;
      logic       load_diff;
      logic       emit;
   } dtf_cmd_type;

   typedef struct packed {
      logic rep_idx;
   } dtf_status_type;

endpackage

>>> rtl/degenerate_triangle_filter_unit.sv
// Degenerate triangle filter: a vertex write is taken while idle and gives no transaction out.
// A triangle with distinct indices makes three reads of the vertex memory's single read port
// and five arithmetic stages before the block is free again; the last stage registers its strobe.
// A triangle with a repeated index emits from the first read state and frees the block at once.
// Synchronous reset returns the controller to idle and the threshold to 1; the vertex memory
// is not cleared. The receiver cannot stall and the result shows for one cycle only.
module degenerate_triangle_filter_unit import dtf_pkg::*; #(
   parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEFAULT,
   parameter int COORD_BITS   = COORD_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  dtf_req_type         req_payload,
   output logic                rsp_strobe,
   output dtf_rsp_type         rsp_payload,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data
);

   dtf_cmd_type    cmd;
   dtf_status_type status;

   dtf_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_payload.cmd),
      .status  (status),
      .busy    (busy),
      .cmd     (cmd)
   );

   dtf_datapath #(
      .VERTEX_DEPTH (VERTEX_DEPTH),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/dtf_ctrl.sv
// Controller state machine sequencing vertex reads and arithmetic stages.
module dtf_ctrl import dtf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           req_cmd,
   input  dtf_status_type status,
   output logic           busy,
   output dtf_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RD_A   = 4'd1;
   localparam logic [3:0] S_RD_B   = 4'd2;
   localparam logic [3:0] S_RD_C   = 4'd3;
   localparam logic [3:0] S_DIFF   = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_CROSS  = 4'd6;
   localparam logic [3:0] S_SQUARE = 4'd7;
   localparam logic [3:0] S_SUM    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_SEL_A;
      case (state_ff)
         S_IDLE: begin
            if (start && req_cmd == CMD_VERTEX) begin
               cmd.vtx_write = 1'b1;
            end
            if (start && req_cmd == CMD_TRIANGLE) begin
               cmd.capture_req = 1'b1;
               state_in        = S_RD_A;
            end
         end
         S_RD_A: begin
            cmd.rd_sel = RD_SEL_A;
            if (status.rep_idx) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RD_B;
            end
         end
         S_RD_B: begin
            cmd.rd_sel  = RD_SEL_B;
            cmd.load_p0 = 1'b1;
            state_in    = S_RD_C;
         end
         S_RD_C: begin
            cmd.rd_sel  = RD_SEL_C;
            cmd.load_p1 = 1'b1;
            state_in    = S_DIFF;
         end
         S_DIFF: begin
            cmd.load_diff = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            state_in = S_CROSS;
         end
         S_CROSS: begin
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> rtl/dtf_datapath.sv
// Datapath: vertex memory, edge differences, cross product, squared length and result.
module dtf_datapath import dtf_pkg::*; #(
   parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEFAULT,
   parameter int COORD_BITS   = COORD_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  dtf_req_type         req_payload,
   input  dtf_cmd_type         cmd,
   output dtf_status_type      status,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data,
   output logic                rsp_strobe,
   output dtf_rsp_type         rsp_payload
);

   localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int CW = COORD_BITS;
   localparam int VW = 3 * CW;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int MW = (PW + 1 > 33) ? PW + 1 : 33;

   logic [VW-1:0] vertex_mem [VERTEX_DEPTH];

   logic [THRESH_W-1:0] thr_ff;
   logic [INDEX_W-1:0]  corner_a_ff, corner_b_ff, corner_c_ff;
   logic                last_ff;
   logic                rep_ff;
   logic                rep_in;

   logic                wr_in_range;
   logic [VW-1:0]       wr_word;
   logic [INDEX_W-1:0]  rd_corner;
   logic                rd_in_range;
   logic [VW-1:0]       rd_word_ff;
   logic                rd_zero_ff;
   logic [VW-1:0]       p_cur;
   logic [VW-1:0]       p0_ff, p1_ff;

   logic signed [CW-1:0] a_co [3];
   logic signed [CW-1:0] b_co [3];
   logic signed [CW-1:0] c_co [3];
   logic signed [DW-1:0] u_in [3];
   logic signed [DW-1:0] v_in [3];
   logic signed [DW-1:0] u_ff [3];
   logic signed [DW-1:0] v_ff [3];
   logic                 eq_in;
   logic                 eq_ff;

   logic signed [PW-1:0] prod_in [6];
   logic signed [PW-1:0] prod_ff [6];

   logic signed [MW-1:0] cross_val [3];
   logic [MW-1:0]        cross_mag [3];
   logic [31:0]          mag_in [3];
   logic [31:0]          mag_ff [3];
   logic [2:0]           big_in;
   logic [2:0]           big_ff;

   logic [63:0]          sq_in [3];
   logic [63:0]          sq_ff [3];
   logic                 ovf_in;
   logic                 ovf_ff;

   logic [65:0]          sum_in;
   logic                 small_area;
   logic [CODE_W-1:0]    code_in;
   logic                 rsp_strobe_ff;
   dtf_rsp_type          rsp_payload_ff;
   dtf_rsp_type          rsp_payload_in;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= MIN_NORMAL_SQ_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Vertex memory: one write port, one registered read port.
   assign wr_in_range = ({20'd0, req_payload.vertex_slot} < 32'(VERTEX_DEPTH));
   assign wr_word = {CW'($signed(req_payload.pos_z)), CW'($signed(req_payload.pos_y)),
                     CW'($signed(req_payload.pos_x))};

   always_ff @(posedge clock) begin
      if (cmd.vtx_write && wr_in_range) begin
         vertex_mem[AW'(req_payload.vertex_slot)] <= wr_word;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_SEL_A: rd_corner = corner_a_ff;
         RD_SEL_B: rd_corner = corner_b_ff;
         RD_SEL_C: rd_corner = corner_c_ff;
         default:  rd_corner = corner_a_ff;
      endcase
   end

   assign rd_in_range = ({20'd0, rd_corner} < 32'(VERTEX_DEPTH));

   always_ff @(posedge clock) begin
      rd_word_ff <= vertex_mem[AW'(rd_corner)];
      rd_zero_ff <= !rd_in_range;
   end

   assign p_cur = rd_zero_ff ? '0 : rd_word_ff;

   // Transaction capture.
   assign rep_in = (req_payload.corner_a == req_payload.corner_b) ||
                   (req_payload.corner_b == req_payload.corner_c) ||
                   (req_payload.corner_c == req_payload.corner_a);

   always_ff @(posedge clock) begin
      if (cmd.capture_req) begin
         corner_a_ff <= req_payload.corner_a;
         corner_b_ff <= req_payload.corner_b;
         corner_c_ff <= req_payload.corner_c;
         last_ff     <= req_payload.last_in;
         rep_ff      <= rep_in;
      end
   end

   assign status.rep_idx = rep_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_p0) begin
         p0_ff <= p_cur;
      end
      if (cmd.load_p1) begin
         p1_ff <= p_cur;
      end
   end

   // Edge vectors and coincidence check.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_co[k] = p0_ff[k*CW +: CW];
         b_co[k] = p1_ff[k*CW +: CW];
         c_co[k] = p_cur[k*CW +: CW];
         u_in[k] = DW'(b_co[k]) - DW'(a_co[k]);
         v_in[k] = DW'(c_co[k]) - DW'(a_co[k]);
      end
   end

   assign eq_in = (p0_ff == p1_ff) || (p1_ff == p_cur) || (p_cur == p0_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         u_ff  <= u_in;
         v_ff  <= v_in;
         eq_ff <= eq_in;
      end
   end

   // Cross product partial products.
   assign prod_in[0] = PW'(u_ff[1]) * PW'(v_ff[2]);
   assign prod_in[1] = PW'(u_ff[2]) * PW'(v_ff[1]);
   assign prod_in[2] = PW'(u_ff[2]) * PW'(v_ff[0]);
   assign prod_in[3] = PW'(u_ff[0]) * PW'(v_ff[2]);
   assign prod_in[4] = PW'(u_ff[0]) * PW'(v_ff[1]);
   assign prod_in[5] = PW'(u_ff[1]) * PW'(v_ff[0]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Cross product components as magnitudes; anything above 32 bits saturates the square.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cross_val[k] = MW'(prod_ff[2*k]) - MW'(prod_ff[2*k+1]);
         cross_mag[k] = cross_val[k][MW-1] ? $unsigned(-cross_val[k])
                                           : $unsigned(cross_val[k]);
         mag_in[k]    = cross_mag[k][31:0];
         big_in[k]    = |cross_mag[k][MW-1:32];
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      big_ff <= big_in;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = 64'(mag_ff[k]) * 64'(mag_ff[k]);
      end
   end

   assign ovf_in = |big_ff;

   always_ff @(posedge clock) begin
      sq_ff  <= sq_in;
      ovf_ff <= ovf_in;
   end

   // Saturating sum and threshold compare.
   assign sum_in = 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
   assign small_area = !ovf_ff && (sum_in[65:64] == 2'd0) && (sum_in[63:0] < thr_ff);

   always_comb begin
      if (rep_ff) begin
         code_in = CODE_REPEAT;
      end else if (eq_ff) begin
         code_in = CODE_COINCIDENT;
      end else if (small_area) begin
         code_in = CODE_SMALL_AREA;
      end else begin
         code_in = CODE_KEEP;
      end
      rsp_payload_in.keep        = (code_in == CODE_KEEP);
      rsp_payload_in.reject_code = code_in;
      rsp_payload_in.out_a       = corner_a_ff;
      rsp_payload_in.out_b       = corner_b_ff;
      rsp_payload_in.out_c       = corner_c_ff;
      rsp_payload_in.last_out    = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> rtl/dtf_checker.sv
// Port-level checker for the degenerate triangle filter, bound to the top level.
module dtf_checker import dtf_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input dtf_req_type         req_payload,
   input logic                rsp_strobe,
   input dtf_rsp_type         rsp_payload
);

   a_tri_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd == CMD_TRIANGLE) |=> busy)
      else $error("Accepted triangle transaction did not raise busy.");

   a_vertex_stays_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd == CMD_VERTEX) |=> !busy)
      else $error("Vertex write transaction raised busy.");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("Result strobe without a triangle in progress.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe held for more than one cycle.");

   a_keep_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.keep == (rsp_payload.reject_code == CODE_KEEP)))
      else $error("Keep flag disagrees with the reject code.");

endmodule

bind degenerate_triangle_filter_unit dtf_checker u_dtf_checker (.*);
